// ----- design/rational_fraction_alu_unit_defines.svh -----
// Assertion macros for the rational fraction ALU checker.
// No dependencies.
`ifndef RATIONAL_FRACTION_ALU_UNIT_DEFINES_SVH
`define RATIONAL_FRACTION_ALU_UNIT_DEFINES_SVH

// same-cycle implication
`define RFA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RFA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/rfa_pkg.sv -----
// Shared constants and command codes for the rational fraction ALU.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rfa_pkg;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int WORD_W = 32;
   localparam int PROD_W = 64;

   localparam logic [3:0] CMD_NORM = 4'd0;
   localparam logic [3:0] CMD_ADD  = 4'd1;
   localparam logic [3:0] CMD_SUB  = 4'd2;
   localparam logic [3:0] CMD_MUL  = 4'd3;
   localparam logic [3:0] CMD_DIV  = 4'd4;
   localparam logic [3:0] CMD_LT   = 4'd5;
   localparam logic [3:0] CMD_GT   = 4'd6;
   localparam logic [3:0] CMD_EQ   = 4'd7;
   localparam logic [3:0] CMD_CLIP = 4'd8;
endpackage
`default_nettype wire

// ----- design/rfa_div.sv -----
// Shared restoring divider, one quotient bit per cycle, quotient and remainder.
// Depends on rfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rfa_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [rfa_pkg::PROD_W-1:0] dividend,
   input  wire logic [rfa_pkg::PROD_W-1:0] divisor,
   output logic                            done,
   output logic [rfa_pkg::PROD_W-1:0]      quot,
   output logic [rfa_pkg::PROD_W-1:0]      rem
);
   localparam int W = rfa_pkg::PROD_W;
   localparam int CW = $clog2(W);
   localparam logic [CW-1:0] LAST = CW'(W - 1);

   logic          run_ff, run_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [W:0]    trial, diff;
   logic          ge;

   assign trial = {r_ff, q_ff[W-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign ge    = trial >= {1'b0, d_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
      end else if (run_ff) begin
         r_in   = ge ? diff[W-1:0] : trial[W-1:0];
         q_in   = {q_ff[W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;
endmodule
`default_nettype wire

// ----- design/rfa_mul.sv -----
// Registered signed multiplier.
// Depends on rfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rfa_mul (
   input  wire logic                              clock,
   input  wire logic signed [rfa_pkg::WORD_W:0]   op_a,
   input  wire logic signed [rfa_pkg::WORD_W:0]   op_b,
   output logic signed [rfa_pkg::PROD_W-1:0]      prod
);
   localparam int FW = 2 * (rfa_pkg::WORD_W + 1);
   logic signed [FW-1:0]             full;
   logic signed [rfa_pkg::PROD_W-1:0] prod_ff;

   assign full = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= full[rfa_pkg::PROD_W-1:0];
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

// ----- design/rational_fraction_alu_unit.sv -----
// Top level of the rational fraction ALU: sequencer, operand registers, put stage.
// Depends on rfa_pkg, rfa_div, rfa_mul.
`timescale 1ns / 1ps
`default_nettype none
// A transaction is taken when start is high and busy is low; busy then stays high
// until the result appears on the rsp_ ports for exactly one cycle with rsp_valid,
// and the receiver cannot stall it. Latency is data dependent: invalid operands
// and comparisons finish without the divider, while the other commands use the
// shared 64-bit bit-serial divider, which runs each Euclid remainder step and the
// two GCD quotients of each reduction (two reductions for multiply and divide);
// clip first shifts both magnitudes right while both have bits at or above sig_bits.
module rational_fraction_alu_unit #(
   parameter int VALUE_WIDTH = rfa_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_cmd,
   input  wire logic [31:0] req_a_num,
   input  wire logic [31:0] req_a_den,
   input  wire logic [31:0] req_b_num,
   input  wire logic [31:0] req_b_den,
   input  wire logic [6:0]  req_sig_bits,
   output logic             rsp_valid,
   output logic [31:0]      rsp_res_num,
   output logic [31:0]      rsp_res_den,
   output logic             rsp_truth
);
   localparam int WW = rfa_pkg::WORD_W;
   localparam int PW = rfa_pkg::PROD_W;
   localparam int W_EFF = (VALUE_WIDTH > WW) ? WW : VALUE_WIDTH;
   localparam logic [PW-1:0] LIM = PW'(1) << (W_EFF - 1);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DISPATCH = 5'd1;
   localparam logic [4:0] S_MUL_P    = 5'd2;
   localparam logic [4:0] S_MUL_Q    = 5'd3;
   localparam logic [4:0] S_MUL_D    = 5'd4;
   localparam logic [4:0] S_MUL_E    = 5'd5;
   localparam logic [4:0] S_CLIP     = 5'd6;
   localparam logic [4:0] S_GCD_CHK  = 5'd7;
   localparam logic [4:0] S_GCD_STEP = 5'd8;
   localparam logic [4:0] S_GCD_WAIT = 5'd9;
   localparam logic [4:0] S_QN_GO    = 5'd10;
   localparam logic [4:0] S_QN_WAIT  = 5'd11;
   localparam logic [4:0] S_QD_GO    = 5'd12;
   localparam logic [4:0] S_QD_WAIT  = 5'd13;
   localparam logic [4:0] S_MUL_U    = 5'd14;
   localparam logic [4:0] S_MUL_V    = 5'd15;
   localparam logic [4:0] S_MUL_W    = 5'd16;
   localparam logic [4:0] S_PUT      = 5'd17;

   function automatic logic [WW-1:0] mag32(input logic [WW-1:0] v);
      mag32 = v[WW-1] ? (~v + 1'b1) : v;
   endfunction

   logic [4:0]           state_ff, state_in;
   logic [3:0]           cmd_ff, cmd_in;
   logic [WW-1:0]        an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [6:0]           sig_ff, sig_in;
   logic [WW-1:0]        mask_ff, mask_in;
   logic [PW-1:0]        pa_ff, pa_in, pb_ff, pb_in;
   logic [PW-1:0]        x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic [WW-1:0]        sa_ff, sa_in, sz_ff, sz_in;
   logic signed [PW-1:0] p_ff, p_in;
   logic                 neg_ff, neg_in, pass_ff, pass_in;
   logic                 rv_ff, rv_in, rt_ff, rt_in;
   logic [WW-1:0]        rn_ff, rn_in, rd_ff, rd_in;

   logic                 div_start, div_done;
   logic [PW-1:0]        div_a, div_b, div_q, div_r;
   logic signed [WW:0]   mul_a, mul_b;
   logic signed [PW-1:0] mul_prod;

   logic                 va, vb;
   logic [WW-1:0]        anm, adm, bnm, bdm;
   logic signed [PW-1:0] sum_v;
   logic                 ng, ovf;

   rfa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   rfa_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   assign va  = !ad_ff[WW-1] && (ad_ff != '0);
   assign vb  = !bd_ff[WW-1] && (bd_ff != '0);
   assign anm = mag32(an_ff);
   assign adm = mag32(ad_ff);
   assign bnm = mag32(bn_ff);
   assign bdm = mag32(bd_ff);
   assign sum_v = (cmd_ff == rfa_pkg::CMD_ADD) ? (p_ff + mul_prod) : (p_ff - mul_prod);
   assign ng  = neg_ff && (pa_ff != '0);
   assign ovf = (ng ? (pa_ff > LIM) : (pa_ff > LIM - 1'b1)) || (pb_ff > LIM - 1'b1);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      an_in     = an_ff;
      ad_in     = ad_ff;
      bn_in     = bn_ff;
      bd_in     = bd_ff;
      sig_in    = sig_ff;
      mask_in   = mask_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      g_in      = g_ff;
      sa_in     = sa_ff;
      sz_in     = sz_ff;
      p_in      = p_ff;
      neg_in    = neg_ff;
      pass_in   = pass_ff;
      rv_in     = 1'b0;
      rt_in     = rt_ff;
      rn_in     = rn_ff;
      rd_in     = rd_ff;
      div_start = 1'b0;
      div_a     = '0;
      div_b     = '0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_cmd;
               an_in    = req_a_num;
               ad_in    = req_a_den;
               bn_in    = req_b_num;
               bd_in    = req_b_den;
               sig_in   = req_sig_bits;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            pass_in = 1'b0;
            rv_in   = 1'b1;
            rt_in   = 1'b0;
            rn_in   = '0;
            rd_in   = '1;
            case (cmd_ff)
               rfa_pkg::CMD_NORM: begin
                  if (ad_ff != '0) begin
                     rv_in    = 1'b0;
                     pa_in    = PW'(anm);
                     pb_in    = PW'(adm);
                     neg_in   = an_ff[WW-1] ^ ad_ff[WW-1];
                     state_in = S_GCD_CHK;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               rfa_pkg::CMD_ADD, rfa_pkg::CMD_SUB: begin
                  if (va && vb) begin
                     rv_in    = 1'b0;
                     state_in = S_MUL_P;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               rfa_pkg::CMD_MUL, rfa_pkg::CMD_DIV: begin
                  if (va && vb && !(cmd_ff == rfa_pkg::CMD_DIV && bn_ff == '0)) begin
                     rv_in    = 1'b0;
                     pa_in    = PW'(anm);
                     pb_in    = (cmd_ff == rfa_pkg::CMD_MUL) ? PW'(bdm) : PW'(bnm);
                     neg_in   = an_ff[WW-1] ^ bn_ff[WW-1];
                     state_in = S_GCD_CHK;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               rfa_pkg::CMD_LT, rfa_pkg::CMD_GT: begin
                  rd_in = '0;
                  if (va && vb) begin
                     rv_in    = 1'b0;
                     state_in = S_MUL_P;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               rfa_pkg::CMD_EQ: begin
                  rd_in    = '0;
                  rt_in    = va && vb && (an_ff == bn_ff) && (ad_ff == bd_ff);
                  state_in = S_IDLE;
               end
               rfa_pkg::CMD_CLIP: begin
                  if (va) begin
                     rv_in    = 1'b0;
                     pa_in    = PW'(anm);
                     pb_in    = PW'(adm);
                     neg_in   = an_ff[WW-1];
                     mask_in  = (sig_ff >= 7'(WW)) ? '0 : ('1 << sig_ff[4:0]);
                     state_in = S_CLIP;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_MUL_P: begin
            mul_a    = {an_ff[WW-1], an_ff};
            mul_b    = {bd_ff[WW-1], bd_ff};
            state_in = S_MUL_Q;
         end
         S_MUL_Q: begin
            p_in     = mul_prod;
            mul_a    = {ad_ff[WW-1], ad_ff};
            mul_b    = {bn_ff[WW-1], bn_ff};
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            if (cmd_ff == rfa_pkg::CMD_LT || cmd_ff == rfa_pkg::CMD_GT) begin
               rv_in    = 1'b1;
               rn_in    = '0;
               rd_in    = '0;
               rt_in    = (cmd_ff == rfa_pkg::CMD_LT) ? (p_ff < mul_prod) : (p_ff > mul_prod);
               state_in = S_IDLE;
            end else begin
               neg_in   = sum_v[PW-1];
               pa_in    = sum_v[PW-1] ? PW'(-sum_v) : PW'(sum_v);
               mul_a    = {1'b0, adm};
               mul_b    = {1'b0, bdm};
               state_in = S_MUL_E;
            end
         end
         S_MUL_E: begin
            pb_in    = PW'(mul_prod);
            state_in = S_GCD_CHK;
         end
         S_CLIP: begin
            if ((pa_ff[WW-1:0] & mask_ff) != '0 && (pb_ff[WW-1:0] & mask_ff) != '0) begin
               pa_in = pa_ff >> 1;
               pb_in = pb_ff >> 1;
            end else if (pa_ff == '0 || pb_ff == '0) begin
               pa_in    = PW'(anm);
               pb_in    = PW'(adm);
               state_in = S_PUT;
            end else begin
               state_in = S_GCD_CHK;
            end
         end
         S_GCD_CHK: begin
            x_in = pa_ff;
            y_in = pb_ff;
            if (pa_ff <= PW'(1) || pb_ff <= PW'(1)) begin
               g_in     = PW'(1);
               state_in = S_QN_GO;
            end else begin
               state_in = S_GCD_STEP;
            end
         end
         S_GCD_STEP: begin
            if (y_ff == '0) begin
               g_in     = x_ff;
               state_in = S_QN_GO;
            end else begin
               div_start = 1'b1;
               div_a     = x_ff;
               div_b     = y_ff;
               state_in  = S_GCD_WAIT;
            end
         end
         S_GCD_WAIT: begin
            if (div_done) begin
               x_in     = y_ff;
               y_in     = div_r;
               state_in = S_GCD_STEP;
            end
         end
         S_QN_GO: begin
            div_start = 1'b1;
            div_a     = pa_ff;
            div_b     = g_ff;
            state_in  = S_QN_WAIT;
         end
         S_QN_WAIT: begin
            if (div_done) begin
               pa_in    = div_q;
               state_in = S_QD_GO;
            end
         end
         S_QD_GO: begin
            div_start = 1'b1;
            div_a     = pb_ff;
            div_b     = g_ff;
            state_in  = S_QD_WAIT;
         end
         S_QD_WAIT: begin
            if (div_done) begin
               pb_in = div_q;
               if (cmd_ff == rfa_pkg::CMD_MUL || cmd_ff == rfa_pkg::CMD_DIV) begin
                  if (!pass_ff) begin
                     sa_in    = pa_ff[WW-1:0];
                     sz_in    = div_q[WW-1:0];
                     pa_in    = (cmd_ff == rfa_pkg::CMD_MUL) ? PW'(bnm) : PW'(bdm);
                     pb_in    = PW'(adm);
                     pass_in  = 1'b1;
                     state_in = S_GCD_CHK;
                  end else begin
                     state_in = S_MUL_U;
                  end
               end else begin
                  state_in = S_PUT;
               end
            end
         end
         S_MUL_U: begin
            mul_a    = {1'b0, sa_ff};
            mul_b    = {1'b0, pa_ff[WW-1:0]};
            state_in = S_MUL_V;
         end
         S_MUL_V: begin
            pa_in    = PW'(mul_prod);
            mul_a    = {1'b0, pb_ff[WW-1:0]};
            mul_b    = {1'b0, sz_ff};
            state_in = S_MUL_W;
         end
         S_MUL_W: begin
            pb_in    = PW'(mul_prod);
            state_in = S_PUT;
         end
         S_PUT: begin
            rv_in    = 1'b1;
            rt_in    = 1'b0;
            rn_in    = ovf ? '0 : (ng ? (~pa_ff[WW-1:0] + 1'b1) : pa_ff[WW-1:0]);
            rd_in    = ovf ? '1 : pb_ff[WW-1:0];
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      cmd_ff  <= cmd_in;
      an_ff   <= an_in;
      ad_ff   <= ad_in;
      bn_ff   <= bn_in;
      bd_ff   <= bd_in;
      sig_ff  <= sig_in;
      mask_ff <= mask_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      g_ff    <= g_in;
      sa_ff   <= sa_in;
      sz_ff   <= sz_in;
      p_ff    <= p_in;
      neg_ff  <= neg_in;
      pass_ff <= pass_in;
      rt_ff   <= rt_in;
      rn_ff   <= rn_in;
      rd_ff   <= rd_in;
   end

   assign busy        = state_ff != S_IDLE;
   assign rsp_valid   = rv_ff;
   assign rsp_res_num = rn_ff;
   assign rsp_res_den = rd_ff;
   assign rsp_truth   = rt_ff;
endmodule
`default_nettype wire

// ----- design/rfa_checker.sv -----
// Port-level checker for the rational fraction ALU, bound to the top level.
// Depends on rational_fraction_alu_unit_defines.svh and rational_fraction_alu_unit.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_fraction_alu_unit_defines.svh"
module rfa_port_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [3:0]  req_cmd,
   input wire logic [31:0] req_a_num,
   input wire logic [31:0] req_a_den,
   input wire logic [31:0] req_b_num,
   input wire logic [31:0] req_b_den,
   input wire logic [6:0]  req_sig_bits,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_res_num,
   input wire logic [31:0] rsp_res_den,
   input wire logic        rsp_truth
);
   `RFA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised")
   `RFA_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_valid, !rsp_valid, "strobe too long")
   `RFA_ASSERT_NOW(a_done_strobe, clock, reset, $fell(busy), rsp_valid, "busy fell, no result")
   `RFA_ASSERT_NOW(a_truth_zero, clock, reset, rsp_valid && rsp_truth, rsp_res_num == 32'd0 && rsp_res_den == 32'd0, "truth with fraction")
   `RFA_ASSERT_NOW(a_invalid_code, clock, reset, rsp_valid && rsp_res_den[31], rsp_res_den == 32'hFFFFFFFF && rsp_res_num == 32'd0, "bad invalid code")
endmodule

bind rational_fraction_alu_unit rfa_port_checker u_rfa_checker (.*);
`default_nettype wire
